[rtl/scpa_pkg.sv]
// scpa_pkg: shared types, codes and widths for the size class pool allocator
// used by scpa_ctrl, scpa_dp and size_class_pool_allocator
package scpa_pkg;

	localparam int OP_W       = 2;
	localparam int SIZE_W     = 16;
	localparam int ADDR_W     = 22;
	localparam int LEN_W      = 13;
	localparam int CNT_W      = 9;
	localparam int STAT_W     = 3;
	localparam int SC_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = LEN_W;
	localparam int CFG_CLASSES = 4;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;
	localparam int PROD_W     = LEN_W + CNT_W;
	localparam int HI_W       = ADDR_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_LEN_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CNT_BASE = 3'd4;
	localparam logic [CNT_W-1:0]     CNT_RESET    = 9'd256;

	typedef enum logic [OP_W-1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NONE  = 2'd3
	} op_e_t;

	typedef enum logic [STAT_W-1:0] {
		ST_ALLOCATED   = 3'd0,
		ST_TOO_LARGE   = 3'd1,
		ST_EXHAUSTED   = 3'd2,
		ST_FREED       = 3'd3,
		ST_NOT_POOLED  = 3'd4,
		ST_OVERFLOW    = 3'd5,
		ST_INITIALIZED = 3'd6,
		ST_NOT_INIT    = 3'd7
	} status_e_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT_CLASS,
		S_INIT_FILL,
		S_INIT_DONE,
		S_ALLOC,
		S_ALLOC_RESP,
		S_FREE_MUL,
		S_FREE_PUSH
	} state_e_t;

	typedef struct packed {
		logic load_in;
		logic init_class;
		logic init_fill;
		logic init_next;
		logic init_done;
		logic alloc_exec;
		logic alloc_resp;
		logic free_mul;
		logic free_exec;
	} cmd_t;

	typedef struct packed {
		logic fill_done;
		logic last_class;
		logic pop;
		logic out_free;
	} sts_t;

	function automatic logic [LEN_W-1:0] len_reset(input int c);
		logic [LEN_W-1:0] v;
		case (c)
			0:       v = 13'd16;
			1:       v = 13'd64;
			2:       v = 13'd256;
			default: v = 13'd1024;
		endcase
		return v;
	endfunction

endpackage

[rtl/scpa_ctrl.sv]
// scpa_ctrl: sequencing state machine for init, alloc and free
// depends on scpa_pkg; drives scpa_dp through cmd_t and reads sts_t
module scpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  scpa_pkg::op_e_t in_op,
	input  scpa_pkg::sts_t  sts,
	output scpa_pkg::cmd_t  cmd
);
	import scpa_pkg::*;

	state_e_t state_q;
	state_e_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (in_op)
						OP_INIT:  state_nx = S_INIT_CLASS;
						OP_ALLOC: state_nx = S_ALLOC;
						OP_FREE:  state_nx = S_FREE_MUL;
						default:  state_nx = S_IDLE;
					endcase
				end
			end
			S_INIT_CLASS: state_nx = S_INIT_FILL;
			S_INIT_FILL: begin
				if (sts.fill_done) begin
					state_nx = sts.last_class ? S_INIT_DONE : S_INIT_CLASS;
				end
			end
			S_INIT_DONE: begin
				if (sts.out_free) state_nx = S_IDLE;
			end
			S_ALLOC: begin
				if (sts.out_free) state_nx = sts.pop ? S_ALLOC_RESP : S_IDLE;
			end
			S_ALLOC_RESP: state_nx = S_IDLE;
			S_FREE_MUL:   state_nx = S_FREE_PUSH;
			S_FREE_PUSH: begin
				if (sts.out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = (state_q == S_IDLE);
		cmd            = '0;
		cmd.load_in    = (state_q == S_IDLE) && s_tvalid;
		cmd.init_class = (state_q == S_INIT_CLASS);
		cmd.init_fill  = (state_q == S_INIT_FILL) && !sts.fill_done;
		cmd.init_next  = (state_q == S_INIT_FILL) && sts.fill_done && !sts.last_class;
		cmd.init_done  = (state_q == S_INIT_DONE) && sts.out_free;
		cmd.alloc_exec = (state_q == S_ALLOC) && sts.out_free;
		cmd.alloc_resp = (state_q == S_ALLOC_RESP);
		cmd.free_mul   = (state_q == S_FREE_MUL);
		cmd.free_exec  = (state_q == S_FREE_PUSH) && sts.out_free;
	end

endmodule

[rtl/scpa_dp.sv]
// scpa_dp: config registers, per class counts and bases, free stack memory,
// range check lanes and result register; depends on scpa_pkg, driven by scpa_ctrl
module scpa_dp #(
	parameter int NUM_CLASSES = 4,
	parameter int MAX_BLOCKS  = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [scpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scpa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  scpa_pkg::op_e_t                     in_op,
	input  logic [scpa_pkg::SIZE_W-1:0]         in_size,
	input  logic [scpa_pkg::ADDR_W-1:0]         in_addr,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output scpa_pkg::status_e_t                 out_status,
	output logic [scpa_pkg::ADDR_W-1:0]         out_addr,
	output logic [scpa_pkg::SC_W-1:0]           out_class,
	output logic [scpa_pkg::CNT_W-1:0]          out_left,
	input  scpa_pkg::cmd_t                      cmd,
	output scpa_pkg::sts_t                      sts
);
	import scpa_pkg::*;

	localparam int DEPTH = NUM_CLASSES * MAX_BLOCKS;
	localparam int MA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CI_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int LAST  = NUM_CLASSES - 1;

	logic [LEN_W-1:0]  len_q    [NUM_CLASSES];
	logic [CNT_W-1:0]  cnt_q    [NUM_CLASSES];
	logic [CNT_W-1:0]  fcount_q [NUM_CLASSES];
	logic [ADDR_W-1:0] cbase_q  [NUM_CLASSES];
	logic [PROD_W-1:0] prod_q   [NUM_CLASSES];
	logic [CNT_W-1:0]  eff      [NUM_CLASSES];
	logic              ready_q;

	op_e_t             op_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] faddr_q;

	logic [CI_W-1:0]   ic_q;
	logic [CNT_W-1:0]  ij_q;
	logic [ADDR_W-1:0] ibase_q;

	logic [ADDR_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] rd_q;
	logic [CI_W-1:0]   acls_q;
	logic [CNT_W-1:0]  aleft_q;

	logic              too_large;
	logic              a_hit;
	logic [CI_W-1:0]   a_cls;
	logic [CNT_W-1:0]  a_top;
	logic              pop;
	logic              f_hit;
	logic [CI_W-1:0]   f_cls;
	logic [CNT_W-1:0]  f_n;
	logic              f_full;
	logic              push;
	logic [HI_W-1:0]   hi;

	logic              wr_en;
	logic [MA_W-1:0]   wr_addr;
	logic [ADDR_W-1:0] wr_data;
	logic              rd_en;
	logic [MA_W-1:0]   rd_addr;

	logic              out_load;
	logic              out_free;
	status_e_t         n_status;
	logic [ADDR_W-1:0] n_addr;
	logic [CI_W-1:0]   n_cls;
	logic [CNT_W-1:0]  n_left;

	function automatic logic [MA_W-1:0] slot(input logic [CI_W-1:0] c, input logic [CNT_W-1:0] n);
		return MA_W'(int'(c) * MAX_BLOCKS + int'(n));
	endfunction

	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			eff[c] = (int'(cnt_q[c]) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : cnt_q[c];
		end
	end

	// alloc: first class that fits and is not empty
	always_comb begin
		too_large = size_q > SIZE_W'(len_q[LAST]);
		a_hit = 1'b0;
		a_cls = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (size_q <= SIZE_W'(len_q[c]) && fcount_q[c] != '0) begin
				a_hit = 1'b1;
				a_cls = CI_W'(c);
			end
		end
		a_top = fcount_q[a_cls] - CNT_W'(1);
		pop   = ready_q && !too_large && a_hit;
	end

	// free: first region holding the address, exact upper bound
	always_comb begin
		f_hit = 1'b0;
		f_cls = '0;
		hi    = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			hi = HI_W'(cbase_q[c]) + HI_W'(prod_q[c]);
			if (faddr_q >= cbase_q[c] && HI_W'(faddr_q) < hi) begin
				f_hit = 1'b1;
				f_cls = CI_W'(c);
			end
		end
		f_n    = fcount_q[f_cls];
		f_full = f_n >= eff[f_cls];
		push   = cmd.free_exec && ready_q && f_hit && !f_full;
	end

	always_comb begin
		wr_en   = cmd.init_fill || push;
		wr_addr = cmd.init_fill ? slot(ic_q, ij_q) : slot(f_cls, f_n);
		wr_data = cmd.init_fill ? ibase_q : faddr_q;
		rd_en   = cmd.alloc_exec && pop;
		rd_addr = slot(a_cls, a_top);
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				len_q[c]    <= len_reset(c);
				cnt_q[c]    <= CNT_RESET;
				fcount_q[c] <= '0;
				cbase_q[c]  <= '0;
			end
			ready_q <= 1'b0;
			ic_q    <= '0;
			ij_q    <= '0;
			ibase_q <= '0;
		end else begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				if (cfg_we && c < CFG_CLASSES) begin
					if (cfg_index == CFG_LEN_BASE + CFG_IDX_W'(c)) len_q[c] <= cfg_wdata;
					if (cfg_index == CFG_CNT_BASE + CFG_IDX_W'(c)) cnt_q[c] <= cfg_wdata[CNT_W-1:0];
				end
			end
			if (cmd.load_in) begin
				ic_q    <= '0;
				ij_q    <= '0;
				ibase_q <= '0;
			end
			if (cmd.init_class) begin
				cbase_q[ic_q]  <= ibase_q;
				fcount_q[ic_q] <= eff[ic_q];
				ij_q           <= '0;
			end
			if (cmd.init_fill) begin
				ibase_q <= ibase_q + ADDR_W'(len_q[ic_q]);
				ij_q    <= ij_q + CNT_W'(1);
			end
			if (cmd.init_next) ic_q <= ic_q + CI_W'(1);
			if (cmd.init_done) ready_q <= 1'b1;
			if (rd_en) fcount_q[a_cls] <= a_top;
			if (push) fcount_q[f_cls] <= f_n + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= in_op;
			size_q  <= in_size;
			faddr_q <= in_addr;
		end
		if (cmd.free_mul) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				prod_q[c] <= PROD_W'(len_q[c]) * PROD_W'(eff[c]);
			end
		end
		if (rd_en) begin
			acls_q  <= a_cls;
			aleft_q <= a_top;
		end
	end

	always_comb begin
		out_load = 1'b0;
		n_status = ST_ALLOCATED;
		n_addr   = '0;
		n_cls    = '0;
		n_left   = '0;
		if (cmd.init_done) begin
			out_load = 1'b1;
			n_status = ST_INITIALIZED;
		end else if (cmd.alloc_exec) begin
			if (!ready_q) begin
				out_load = 1'b1;
				n_status = ST_NOT_INIT;
			end else if (too_large) begin
				out_load = 1'b1;
				n_status = ST_TOO_LARGE;
			end else if (!a_hit) begin
				out_load = 1'b1;
				n_status = ST_EXHAUSTED;
			end
		end else if (cmd.alloc_resp) begin
			out_load = 1'b1;
			n_status = ST_ALLOCATED;
			n_addr   = rd_q;
			n_cls    = acls_q;
			n_left   = aleft_q;
		end else if (cmd.free_exec) begin
			out_load = 1'b1;
			if (!ready_q) begin
				n_status = ST_NOT_INIT;
			end else if (!f_hit) begin
				n_status = ST_NOT_POOLED;
			end else if (f_full) begin
				n_status = ST_OVERFLOW;
				n_cls    = f_cls;
				n_left   = f_n;
			end else begin
				n_status = ST_FREED;
				n_cls    = f_cls;
				n_left   = f_n + CNT_W'(1);
			end
		end
	end

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status <= n_status;
			out_addr   <= n_addr;
			out_class  <= SC_W'(n_cls);
			out_left   <= n_left;
		end
	end

	always_comb begin
		sts.fill_done  = (ij_q == eff[ic_q]);
		sts.last_class = (ic_q == CI_W'(LAST));
		sts.pop        = pop;
		sts.out_free   = out_free && (op_q != OP_NONE);
	end

endmodule

[rtl/size_class_pool_allocator.sv]
// size_class_pool_allocator: top level, stream ports and config write port
// depends on scpa_pkg, scpa_ctrl and scpa_dp
//
//   channel  signals                       direction  carries
//   s_*      tvalid tready tdata tuser     in         operation request
//   m_*      tvalid tready tdata tuser     out        one result per init/alloc/free
//   cfg_*    we index wdata                in         block length and count registers
//
// alloc: S_ALLOC then S_ALLOC_RESP before the result register loads (alloc waits on
// the stack memory's registered read); free: S_FREE_MUL for the per class range multiply, then S_FREE_PUSH;
// an alloc refused before init, for size or for empty pools answers from S_ALLOC
// init: S_INIT_CLASS and S_INIT_FILL for each class, then S_INIT_DONE, one stack
// entry written per cycle; op 3 is accepted and gives no result
// a pending result holds in the output register; a new item is accepted while it
// waits and completes when the register drains
// the stack memory needs no clearing pass after reset
module size_class_pool_allocator #(
	parameter int NUM_CLASSES = 4,
	parameter int MAX_BLOCKS  = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [scpa_pkg::IN_DATA_W-1:0]      s_tdata,  // request_size, free_address
	input  logic [scpa_pkg::OP_W-1:0]           s_tuser,  // operation
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [scpa_pkg::OUT_DATA_W-1:0]     m_tdata,  // block_address, size_class, blocks_left
	output logic [scpa_pkg::STAT_W-1:0]         m_tuser,  // status
	input  logic                                cfg_we,
	input  logic [scpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import scpa_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	op_e_t             in_op;
	status_e_t         out_status;
	logic [ADDR_W-1:0] out_addr;
	logic [SC_W-1:0]   out_class;
	logic [CNT_W-1:0]  out_left;

	assign in_op = op_e_t'(s_tuser);

	scpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_op    (in_op),
		.sts      (sts),
		.cmd      (cmd)
	);

	scpa_dp #(
		.NUM_CLASSES (NUM_CLASSES),
		.MAX_BLOCKS  (MAX_BLOCKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_op      (in_op),
		.in_size    (s_tdata[SIZE_W-1:0]),
		.in_addr    (s_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.out_status (out_status),
		.out_addr   (out_addr),
		.out_class  (out_class),
		.out_left   (out_left),
		.cmd        (cmd),
		.sts        (sts)
	);

	assign m_tuser = out_status;
	assign m_tdata = {(OUT_DATA_W - ADDR_W - SC_W - CNT_W)'(0), out_left, out_class, out_addr};

endmodule

[bench/tb.sv]
// tb: self-checking bench for size_class_pool_allocator (init, alloc and free streams)
// depends on scpa_pkg and size_class_pool_allocator; keeps its own copy of the pool state
// to predict each result, checks results in order, varies both sides' idling and the registers
`timescale 1ns / 1ps

module tb;
	import scpa_pkg::*;

	localparam int CLASSES     = 4;
	localparam int MAX_BLK     = 256;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		op_e_t       op;
		logic [15:0] size;
		logic [21:0] addr;
	} request_t;

	typedef struct packed {
		status_e_t   st;
		logic [21:0] addr;
		logic [1:0]  cls;
		logic [8:0]  left;
	} outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// pool state mirrored from the block
	logic [21:0] stack_mem [0:CLASSES*MAX_BLK-1];
	logic [8:0]  fcnt [CLASSES];
	logic [21:0] cbase [CLASSES];
	bit          ready;
	logic [12:0] blen [CLASSES];
	logic [8:0]  bcnt [CLASSES];

	// layout the stimulus aims at, set when an init is queued
	longint   plan_base [CLASSES];
	request_t request_q [$];
	outcome_t outcome_q [$];
	request_t cur;
	int       send_idle;
	int       recv_idle;
	int       hold_req;
	int       hold_seen;
	int       hold_cnt;
	int       mismatches;
	int       stall_cnt;

	size_class_pool_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic int sat_count(int c);
		return (bcnt[c] > 9'd256) ? MAX_BLK : int'(bcnt[c]);
	endfunction

	function automatic outcome_t pool_outcome(request_t r);
		outcome_t o;
		longint   b;
		longint   lo;
		longint   hi;
		int       n;
		bit       hit;
		o = '0;
		hit = 1'b0;
		if (r.op == OP_INIT) begin
			b = 0;
			for (int c = 0; c < CLASSES; c++) begin
				n = sat_count(c);
				cbase[c] = 22'(b);
				for (int j = 0; j < n; j++)
					stack_mem[c*MAX_BLK + j] = 22'(b + longint'(j) * blen[c]);
				fcnt[c] = 9'(n);
				b = b + longint'(blen[c]) * n;
			end
			ready = 1'b1;
			o.st = ST_INITIALIZED;
		end else if (!ready) begin
			o.st = ST_NOT_INIT;
		end else if (r.op == OP_ALLOC) begin
			if (r.size > blen[CLASSES-1]) begin
				o.st = ST_TOO_LARGE;
			end else begin
				o.st = ST_EXHAUSTED;
				for (int c = 0; c < CLASSES; c++) begin
					if (!hit && r.size <= blen[c] && fcnt[c] != 0) begin
						hit = 1'b1;
						fcnt[c] = fcnt[c] - 9'd1;
						o.st = ST_ALLOCATED;
						o.addr = stack_mem[c*MAX_BLK + fcnt[c]];
						o.cls = 2'(c);
						o.left = fcnt[c];
					end
				end
			end
		end else begin
			o.st = ST_NOT_POOLED;
			for (int c = 0; c < CLASSES; c++) begin
				lo = cbase[c];
				hi = lo + longint'(blen[c]) * sat_count(c);
				if (!hit && longint'(r.addr) >= lo && longint'(r.addr) < hi) begin
					hit = 1'b1;
					o.cls = 2'(c);
					if (fcnt[c] >= sat_count(c)) begin
						o.st = ST_OVERFLOW;
						o.left = fcnt[c];
					end else begin
						stack_mem[c*MAX_BLK + fcnt[c]] = r.addr;
						fcnt[c] = fcnt[c] + 9'd1;
						o.st = ST_FREED;
						o.left = fcnt[c];
					end
				end
			end
		end
		return o;
	endfunction

	// request driver
	always @(posedge clk) begin : drive
		bit offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				if (cur.op != OP_NONE)
					outcome_q.push_back(pool_outcome(cur));
				offer = 1'b0;
			end
			if (!offer && request_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				cur = request_q.pop_front();
				offer = 1'b1;
			end
			s_tvalid <= offer;
			s_tdata <= {2'b00, cur.addr, cur.size};
			s_tuser <= cur.op;
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 20)
				$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// result monitor
	always @(posedge clk) begin : watch
		outcome_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					mismatches++;
					$display("%0t unexpected result: expected none actual %0h %0h",
						$time, m_tuser, m_tdata);
				end else begin
					want = outcome_q.pop_front();
					check_field("status", want.st, m_tuser);
					check_field("block_address", want.addr, m_tdata[21:0]);
					check_field("size_class", want.cls, m_tdata[23:22]);
					check_field("blocks_left", want.left, m_tdata[32:24]);
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_cnt = HOLD_CYCLES;
			end else if (hold_cnt != 0) begin
				hold_cnt--;
			end
			m_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic cfg_wr(logic [CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		if (idx < CFG_CNT_BASE)
			blen[idx[1:0]] = 13'(val);
		else
			bcnt[2'(idx - CFG_CNT_BASE)] = 9'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic cfg_class(int c, int len, int cnt);
		cfg_wr(CFG_LEN_BASE + 3'(c), len);
		cfg_wr(CFG_CNT_BASE + 3'(c), cnt);
	endtask

	task automatic cfg_random();
		int q;
		int len;
		int cnt;
		for (int c = 0; c < CLASSES; c++) begin
			q = $urandom_range(0, 99);
			if (q < 15)
				len = ($urandom_range(0, 1) != 0) ? 4096 : 1;
			else if (q < 45)
				len = $urandom_range(1, 4096);
			else
				len = $urandom_range(1, 64);
			q = $urandom_range(0, 99);
			if (q < 10)
				cnt = 256;
			else if (q < 20)
				cnt = 0;
			else
				cnt = $urandom_range(1, 8);
			cfg_class(c, len, cnt);
		end
	endtask

	task automatic push(op_e_t op, int size, int addr);
		request_t r;
		longint   b;
		r.op = op;
		r.size = 16'(size);
		r.addr = 22'(addr);
		if (op == OP_INIT) begin
			b = 0;
			for (int c = 0; c < CLASSES; c++) begin
				plan_base[c] = b;
				b = b + longint'(blen[c]) * sat_count(c);
			end
		end
		request_q.push_back(r);
	endtask

	function automatic int pick_size(int c);
		int q;
		q = $urandom_range(0, 99);
		if (q < 60)
			return $urandom_range(0, blen[c]);
		if (q < 75)
			return blen[c] + $urandom_range(0, 1);
		if (q < 85)
			return 0;
		return $urandom_range(0, 65535);
	endfunction

	function automatic int pick_addr(int c);
		int     q;
		int     n;
		longint lo;
		longint span;
		lo = plan_base[c];
		n = sat_count(c);
		span = longint'(blen[c]) * n;
		q = $urandom_range(0, 99);
		if (q < 55 && n > 0)
			return int'((lo + longint'($urandom_range(0, n - 1)) * blen[c]) & 64'h3FFFFF);
		if (q < 70) begin
			case ($urandom_range(0, 3))
				0: return int'((lo - 1) & 64'h3FFFFF);
				1: return int'(lo & 64'h3FFFFF);
				2: return int'((lo + span - 1) & 64'h3FFFFF);
				default: return int'((lo + span) & 64'h3FFFFF);
			endcase
		end
		if (q < 85 && span > 0)
			return int'((lo + longint'($urandom) % span) & 64'h3FFFFF);
		return $urandom_range(0, 22'h3FFFFF);
	endfunction

	task automatic push_random(int n);
		int p;
		int c;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			c = $urandom_range(0, CLASSES - 1);
			if (p < 46)
				push(OP_ALLOC, pick_size(c), 0);
			else if (p < 92)
				push(OP_FREE, 0, pick_addr(c));
			else if (p < 95)
				push(OP_NONE, $urandom_range(0, 65535), $urandom_range(0, 22'h3FFFFF));
			else if (p < 98)
				push(($urandom_range(0, 1) != 0) ? OP_ALLOC : OP_FREE,
					$urandom_range(0, 65535), $urandom_range(0, 22'h3FFFFF));
			else
				push(OP_INIT, $urandom_range(0, 65535), $urandom_range(0, 22'h3FFFFF));
		end
	endtask

	// wait until every request has been taken and every result has come back
	task automatic drain();
		do
			@(negedge clk);
		while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_idle(int snd, int rcv);
		@(negedge clk);
		send_idle = snd;
		recv_idle = rcv;
	endtask

	initial begin
		for (int c = 0; c < CLASSES; c++) begin
			blen[c] = len_reset(c);
			bcnt[c] = CNT_RESET;
			fcnt[c] = '0;
			cbase[c] = '0;
			plan_base[c] = 0;
		end
		for (int i = 0; i < CLASSES*MAX_BLK; i++)
			stack_mem[i] = '0;
		ready = 1'b0;
		cur = '0;
		send_idle = 17;
		recv_idle = 46;
		hold_req = 0;
		hold_seen = 0;
		hold_cnt = 0;
		mismatches = 0;
		stall_cnt = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values: before init, unknown op, first fit and size limits
		@(negedge clk);
		push(OP_ALLOC, 16, 0);
		push(OP_FREE, 0, 0);
		push(OP_NONE, 16'hFFFF, 22'h3FFFFF);
		push(OP_INIT, 0, 0);
		push(OP_ALLOC, 0, 0);
		push(OP_ALLOC, 17, 0);
		push(OP_ALLOC, 1025, 0);
		push(OP_ALLOC, 65535, 0);
		push(OP_FREE, 0, 20480);
		push(OP_FREE, 0, 22'h3FFFFF);
		drain();

		// re-init with tiny classes, a zero length class and an empty class
		cfg_class(0, 1, 3);
		cfg_class(1, 0, 2);
		cfg_class(2, 4096, 0);
		cfg_class(3, 4096, 1);
		@(negedge clk);
		push(OP_INIT, 0, 0);
		for (int i = 0; i < 7; i++)
			push(OP_ALLOC, 0, 0);
		push(OP_FREE, 0, 3);
		push(OP_FREE, 0, 0);
		push(OP_FREE, 0, 1);
		push(OP_ALLOC, 4097, 0);
		push(OP_FREE, 0, 4099);
		drain();

		// largest layout, fills the whole address space
		for (int c = 0; c < CLASSES; c++)
			cfg_class(c, 4096, 256);
		@(negedge clk);
		push(OP_INIT, 0, 0);
		push_random(150);
		drain();

		set_idle(46, 17);
		cfg_random();
		@(negedge clk);
		push(OP_INIT, 0, 0);
		hold_req++;
		push_random(270);
		drain();

		// registers change under an existing layout
		cfg_random();
		@(negedge clk);
		push_random(270);
		drain();

		cfg_random();
		@(negedge clk);
		push(OP_INIT, 0, 0);
		push_random(270);
		drain();

		set_idle(0, 0);
		for (int k = 0; k < 2; k++) begin
			cfg_random();
			@(negedge clk);
			push(OP_INIT, 0, 0);
			push_random(270);
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
